// File: src/hrc_pkg.sv
// ---------------------------------------------------------------------------
// hrc_pkg: constants for the heater resistance code pipeline
// Offsets, scale factors and reciprocal multipliers of the heater formula,
// plus the register index codes of the configuration port.
// ---------------------------------------------------------------------------
package hrc_pkg;

   // Pipeline shape: six formula stages, divider setup, one stage per
   // quotient bit, two rounding stages
   localparam int NUM_STAGES = 20;
   localparam int DIV_BITS   = 11;
   localparam int DIV_SETUP  = 6;
   localparam int RND_STAGE  = DIV_SETUP + DIV_BITS + 1;
   localparam int LAST_STAGE = NUM_STAGES - 1;

   // Register index codes
   localparam logic [2:0] REG_AMBIENT_TEMP = 3'd0;
   localparam logic [2:0] REG_CAL_G1       = 3'd1;
   localparam logic [2:0] REG_CAL_G2       = 3'd2;
   localparam logic [2:0] REG_CAL_G3       = 3'd3;
   localparam logic [2:0] REG_HEAT_RANGE   = 3'd4;
   localparam logic [2:0] REG_HEAT_VALUE   = 3'd5;

   // Register reset values
   localparam logic [7:0] AMBIENT_RESET = 8'd25;

   // Formula constants
   localparam logic [8:0]  TEMP_LIMIT  = 9'd400;
   localparam logic [9:0]  G1_OFFSET   = 10'd784;
   localparam logic [18:0] G2_OFFSET   = 19'd154009;
   localparam logic [22:0] V2_OFFSET   = 23'd3276800;
   localparam logic [17:0] HV_OFFSET   = 18'd65536;
   localparam logic [17:0] CODE_OFFSET = 18'd250;
   localparam logic [17:0] ROUND_BIAS  = 18'd50;

   // Reciprocals: floor(a / d) = (a * ceil(2^k / d)) >> k over the ranges used
   localparam logic [14:0] RECIP_1000 = 15'd16778;     // k = 24, a < 2^15
   localparam logic [24:0] RECIP_5_A  = 25'd26843546;  // k = 27, a < 2^25
   localparam logic [21:0] RECIP_5_B  = 22'd3355444;   // k = 24, a < 2^22
   localparam logic [16:0] RECIP_100  = 17'd83887;     // k = 23, a < 2^16

   // Multiplier for division by heat_range + 4, all with k = 32, a < 2^29
   function automatic logic [30:0] range_recip(input logic [1:0] range);
      logic [30:0] m;
      case (range)
         2'd0:    m = 31'd1073741824;  // divide by 4
         2'd1:    m = 31'd858993460;   // divide by 5
         2'd2:    m = 31'd715827883;   // divide by 6
         2'd3:    m = 31'd613566757;   // divide by 7
         default: m = 31'd1073741824;
      endcase
      return m;
   endfunction

endpackage

// File: src/heater_resistance_code.sv
// ---------------------------------------------------------------------------
// heater_resistance_code: target temperature to heater resistance code
// Evaluates the integer heater formula over a 20-stage pipeline with a
// one-bit-per-stage restoring divider and a two-entry result buffer.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req_     in         req_tvalid/tready     target_temp [15:0]
//   rsp_     out        rsp_tvalid/tready     heater_code [7:0]
//   csr_     in         csr_valid/ready       csr_index [2:0], csr_data [15:0]
//
// One transaction is accepted per cycle while the buffer has room; a result
// reaches rsp_ through the eleven quotient-bit stages of the divider and the
// nine formula, setup and rounding stages around it, then the result buffer.
// The whole pipeline advances together while the result buffer has room;
// it holds, losing nothing, only when both buffer entries wait.
// Synchronous reset clears valid bits, the buffer count and the config registers (ambient to 25).
// csr_ready is always high; writes go in only while no transaction is in flight, a rule left to the user.

module heater_resistance_code
   import hrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] target_temp
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [7:0] heater_code
);

   // Configuration registers
   logic [7:0]  ambient_temp_ff, ambient_temp_in;
   logic [7:0]  cal_g1_ff, cal_g1_in;
   logic [15:0] cal_g2_ff, cal_g2_in;
   logic [7:0]  cal_g3_ff, cal_g3_in;
   logic [1:0]  heat_range_ff, heat_range_in;
   logic [7:0]  heat_value_ff, heat_value_in;

   // Pipeline control
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic                  advance;

   // Stage registers
   logic [26:0]        s0_n_ff, s0_n_in;
   logic signed [15:0] s0_pa_ff, s0_pa_in;
   logic [48:0]        s1_m_ff, s1_m_in;
   logic [28:0]        s1_a_ff, s1_a_in;
   logic               s1_neg_ff, s1_neg_in;
   logic [43:0]        s2_m_ff, s2_m_in;
   logic [13:0]        s2_v1_ff, s2_v1_in;
   logic [29:0]        s3_v2_ff, s3_v2_in;
   logic [13:0]        s3_v1_ff, s3_v1_in;
   logic [28:0]        s4_v3_ff, s4_v3_in;
   logic [58:0]        s5_p_ff, s5_p_in;
   logic [16:0]        dv_rem_ff [0:DIV_BITS-1];
   logic [16:0]        dv_rem_in [0:DIV_BITS-1];
   logic [10:0]        dv_dvd_ff [0:DIV_BITS-1];
   logic [10:0]        dv_dvd_in [0:DIV_BITS-1];
   logic [10:0]        dv_quo_ff [0:DIV_BITS];
   logic [10:0]        dv_quo_in [0:DIV_BITS];
   logic [15:0]        s18_mag_ff, s18_mag_in;
   logic               s18_neg_ff, s18_neg_in;
   logic [30:0]        s19_p_ff, s19_p_in;
   logic               s19_neg_ff, s19_neg_in;

   // Result buffer
   logic [1:0] count_ff, count_in;
   logic [7:0] out0_ff, out0_in;
   logic [7:0] out1_ff, out1_in;

   // Combinational intermediates
   logic [8:0]  t_clamp;
   logic [18:0] g2_sum;
   logic [15:0] pa_mag;
   logic [22:0] v2_pre;
   logic [13:0] v1_mag;
   logic [9:0]  g1_sum;
   logic [30:0] v3_sum;
   logic [17:0] hv_ext;
   logic [17:0] v5_full;
   logic [16:0] v5;
   logic [17:0] q_diff;
   logic [17:0] d_round;
   logic [17:0] d_mag;
   logic [7:0]  rq_low;
   logic [7:0]  push_code;
   logic        push;
   logic        pop;

   // -----------------------------------------------------------------------
   // Configuration port
   // -----------------------------------------------------------------------
   assign csr_ready = 1'b1;

   // Decode the register index; ignore indexes past the list
   always_comb begin
      ambient_temp_in = ambient_temp_ff;
      cal_g1_in       = cal_g1_ff;
      cal_g2_in       = cal_g2_ff;
      cal_g3_in       = cal_g3_ff;
      heat_range_in   = heat_range_ff;
      heat_value_in   = heat_value_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_AMBIENT_TEMP: ambient_temp_in = csr_data[7:0];
            REG_CAL_G1:       cal_g1_in       = csr_data[7:0];
            REG_CAL_G2:       cal_g2_in       = csr_data;
            REG_CAL_G3:       cal_g3_in       = csr_data[7:0];
            REG_HEAT_RANGE:   heat_range_in   = csr_data[1:0];
            REG_HEAT_VALUE:   heat_value_in   = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ambient_temp_ff <= AMBIENT_RESET;
         cal_g1_ff       <= '0;
         cal_g2_ff       <= '0;
         cal_g3_ff       <= '0;
         heat_range_ff   <= '0;
         heat_value_ff   <= '0;
      end else begin
         ambient_temp_ff <= ambient_temp_in;
         cal_g1_ff       <= cal_g1_in;
         cal_g2_ff       <= cal_g2_in;
         cal_g3_ff       <= cal_g3_in;
         heat_range_ff   <= heat_range_in;
         heat_value_ff   <= heat_value_in;
      end
   end

   // -----------------------------------------------------------------------
   // Pipeline control: advance while the result buffer has a free entry
   // -----------------------------------------------------------------------
   assign advance    = ~count_ff[1];
   assign req_tready = advance;
   assign vld_in     = {vld_ff[NUM_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // -----------------------------------------------------------------------
   // Stage 0: clamp target, (g2 + offset) * t, ambient * g3
   // -----------------------------------------------------------------------
   always_comb begin
      t_clamp  = (req_tdata > {7'd0, TEMP_LIMIT}) ? TEMP_LIMIT : req_tdata[8:0];
      g2_sum   = {{3{cal_g2_ff[15]}}, cal_g2_ff} + G2_OFFSET;
      s0_n_in  = 27'(g2_sum[17:0]) * 27'(t_clamp);
      s0_pa_in = $signed(ambient_temp_ff) * $signed(cal_g3_ff);
   end

   // -----------------------------------------------------------------------
   // Stage 1: n / 20 as (n >> 2) / 5, magnitude of ambient product / 1000
   // -----------------------------------------------------------------------
   always_comb begin
      s1_m_in   = 49'(s0_n_ff[26:2]) * 49'(RECIP_5_A);
      s1_neg_in = s0_pa_ff[15];
      pa_mag    = s1_neg_in ? (16'd0 - s0_pa_ff) : s0_pa_ff;
      s1_a_in   = 29'(pa_mag[14:0]) * 29'(RECIP_1000);
   end

   // -----------------------------------------------------------------------
   // Stage 2: add offset, divide by 10 as (w >> 1) / 5; form signed v1
   // -----------------------------------------------------------------------
   always_comb begin
      v2_pre   = 23'(s1_m_ff[48:27]) + V2_OFFSET;
      s2_m_in  = 44'(v2_pre[22:1]) * 44'(RECIP_5_B);
      v1_mag   = {1'b0, s1_a_ff[28:24], 8'd0};
      s2_v1_in = s1_neg_ff ? (14'd0 - v1_mag) : v1_mag;
   end

   // -----------------------------------------------------------------------
   // Stage 3: v2 = (g1 + 784) * quotient
   // -----------------------------------------------------------------------
   always_comb begin
      g1_sum   = {{2{cal_g1_ff[7]}}, cal_g1_ff} + G1_OFFSET;
      s3_v2_in = 30'(s2_m_ff[43:24]) * 30'(g1_sum);
      s3_v1_in = s2_v1_ff;
   end

   // -----------------------------------------------------------------------
   // Stage 4: v3 = v1 + v2 / 2, always positive
   // -----------------------------------------------------------------------
   always_comb begin
      v3_sum   = {{17{s3_v1_ff[13]}}, s3_v1_ff} + {2'd0, s3_v2_ff[29:1]};
      s4_v3_in = v3_sum[28:0];
   end

   // -----------------------------------------------------------------------
   // Stage 5: v3 / (heat_range + 4) by reciprocal multiply
   // -----------------------------------------------------------------------
   always_comb begin
      s5_p_in = 59'(s4_v3_ff) * 59'(range_recip(heat_range_ff));
   end

   // -----------------------------------------------------------------------
   // Divider: v4 / v5, v5 = 131 * heat_value + 65536, quotient below 2^11
   // -----------------------------------------------------------------------
   always_comb begin
      hv_ext  = {{10{heat_value_ff[7]}}, heat_value_ff};
      v5_full = (hv_ext << 7) + (hv_ext << 1) + hv_ext + HV_OFFSET;
      v5      = v5_full[16:0];
   end

   // Setup stage: the top bits of v4 start as the partial remainder
   always_comb begin
      dv_rem_in[0] = {1'b0, s5_p_ff[58:43]};
      dv_dvd_in[0] = s5_p_ff[42:32];
      dv_quo_in[0] = '0;
   end

   // One quotient bit per stage, most significant first
   for (genvar j = 1; j <= DIV_BITS; j++) begin : g_div
      logic [17:0] r_ext;
      logic        ge;

      always_comb begin
         r_ext        = {dv_rem_ff[j-1], dv_dvd_ff[j-1][10]};
         ge           = (r_ext >= {1'b0, v5});
         dv_quo_in[j] = {dv_quo_ff[j-1][9:0], ge};
      end

      if (j < DIV_BITS) begin : g_rem
         logic [17:0] r_sub;

         always_comb begin
            r_sub        = r_ext - {1'b0, v5};
            dv_rem_in[j] = ge ? r_sub[16:0] : r_ext[16:0];
            dv_dvd_in[j] = {dv_dvd_ff[j-1][9:0], 1'b0};
         end
      end
   end

   // -----------------------------------------------------------------------
   // Rounding stage: d = (q - 250) * 34 + 50, split into sign and magnitude
   // -----------------------------------------------------------------------
   always_comb begin
      q_diff     = {7'd0, dv_quo_ff[DIV_BITS]} - CODE_OFFSET;
      d_round    = (q_diff << 5) + (q_diff << 1) + ROUND_BIAS;
      s18_neg_in = d_round[17];
      d_mag      = s18_neg_in ? (18'd0 - d_round) : d_round;
      s18_mag_in = d_mag[15:0];
   end

   // -----------------------------------------------------------------------
   // Last stage: |d| / 100 by reciprocal, low bits only
   // -----------------------------------------------------------------------
   always_comb begin
      s19_p_in   = 31'(s18_mag_ff) * 31'(RECIP_100);
      s19_neg_in = s18_neg_ff;
   end

   // Advance all data stages together
   always_ff @(posedge clock) begin
      if (advance) begin
         s0_n_ff    <= s0_n_in;
         s0_pa_ff   <= s0_pa_in;
         s1_m_ff    <= s1_m_in;
         s1_a_ff    <= s1_a_in;
         s1_neg_ff  <= s1_neg_in;
         s2_m_ff    <= s2_m_in;
         s2_v1_ff   <= s2_v1_in;
         s3_v2_ff   <= s3_v2_in;
         s3_v1_ff   <= s3_v1_in;
         s4_v3_ff   <= s4_v3_in;
         s5_p_ff    <= s5_p_in;
         s18_mag_ff <= s18_mag_in;
         s18_neg_ff <= s18_neg_in;
         s19_p_ff   <= s19_p_in;
         s19_neg_ff <= s19_neg_in;
         for (int i = 0; i < DIV_BITS; i++) begin
            dv_rem_ff[i] <= dv_rem_in[i];
            dv_dvd_ff[i] <= dv_dvd_in[i];
         end
         for (int i = 0; i <= DIV_BITS; i++) begin
            dv_quo_ff[i] <= dv_quo_in[i];
         end
      end
   end

   // -----------------------------------------------------------------------
   // Result buffer: two entries, head drives rsp_tdata
   // -----------------------------------------------------------------------
   always_comb begin
      rq_low    = s19_p_ff[30:23];
      push_code = s19_neg_ff ? (8'd0 - rq_low) : rq_low;
      push      = advance & vld_ff[LAST_STAGE];
      pop       = rsp_tvalid & rsp_tready;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};

      out0_in = out0_ff;
      out1_in = out1_ff;
      if (pop) begin
         out0_in = (count_ff == 2'd2) ? out1_ff : push_code;
      end else if (push && (count_ff == 2'd0)) begin
         out0_in = push_code;
      end
      if (push && !pop && (count_ff == 2'd1)) begin
         out1_in = push_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = out0_ff;

   // -----------------------------------------------------------------------
   // Assertions
   // -----------------------------------------------------------------------
   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_SETUP] |-> (dv_rem_ff[0] < v5))
      else $error("divider quotient exceeds eleven bits");

   a_v3_positive: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> !v3_sum[30])
      else $error("v3 went negative");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (vld_ff == $past(vld_ff)))
      else $error("pipeline moved during a stall");

   a_stall_push: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST_STAGE] && count_ff == 2'd2 && !rsp_tready)
         |=> vld_ff[LAST_STAGE])
      else $error("result dropped while buffer full");

endmodule

// File: tb/sv/heater_code_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heater_code_checker: scoreboard for the heater resistance code block
// Tracks configuration writes, predicts the heater code for every accepted
// request and compares each accepted response against the oldest prediction.
// ---------------------------------------------------------------------------

module heater_code_checker
   import hrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] target_temp
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] heater_code
   output int          fail_count,
   output int          pending_count
);

   // Formula constants, held as 64-bit signed so every step stays signed
   localparam longint TARGET_MAX    = 400;
   localparam longint G1_BIAS       = 784;
   localparam longint G2_BIAS       = 154009;
   localparam longint SPAN_BIAS     = 3276800;
   localparam longint HV_GAIN       = 131;
   localparam longint HV_BIAS       = 65536;
   localparam longint CODE_BIAS     = 250;
   localparam longint CODE_GAIN     = 34;
   localparam longint AMBIENT_SCALE = 1000;

   typedef struct {
      logic [15:0] target;
      logic [7:0]  code;
   } heater_expect_type;

   heater_expect_type expected_codes[$];

   // Shadow copy of the configuration registers
   logic signed [7:0]  ambient_r;
   logic signed [7:0]  g1_r;
   logic signed [15:0] g2_r;
   logic signed [7:0]  g3_r;
   logic        [1:0]  range_r;
   logic signed [7:0]  hv_r;

   // Evaluate the heater formula with truncating divisions
   function automatic logic [7:0] predict_heater_code(input logic [15:0] target);
      longint t, v1, v2, v3, v4, v5, x, r;
      t = target;
      if (t > TARGET_MAX) t = TARGET_MAX;
      v1 = ((longint'(ambient_r) * longint'(g3_r)) / AMBIENT_SCALE) * 256;
      v2 = (longint'(g1_r) + G1_BIAS) *
           ((((longint'(g2_r) + G2_BIAS) * t * 5) / 100 + SPAN_BIAS) / 10);
      v3 = v1 + v2 / 2;
      v4 = v3 / (longint'(range_r) + 4);
      v5 = HV_GAIN * longint'(hv_r) + HV_BIAS;
      x  = ((v4 / v5) - CODE_BIAS) * CODE_GAIN;
      r  = (x + 50) / 100;
      return r[7:0];
   endfunction

   always @(posedge clock) begin
      heater_expect_type head;
      heater_expect_type item;
      if (reset) begin
         ambient_r     <= 8'sd25;
         g1_r          <= '0;
         g2_r          <= '0;
         g3_r          <= '0;
         range_r       <= '0;
         hv_r          <= '0;
         fail_count    <= 0;
         pending_count <= 0;
         expected_codes.delete();
      end else begin
         // Compare the response transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_codes.size() == 0) begin
               $display("%0t: unexpected heater_code: expected none, actual %0d",
                        $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               head = expected_codes.pop_front();
               if (rsp_tdata !== head.code) begin
                  $display("%0t: heater_code mismatch, target %0d: expected %0d, actual %0d",
                           $time, head.target, head.code, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // Predict the result of the request transaction
         if (req_tvalid && req_tready) begin
            item.target = req_tdata;
            item.code   = predict_heater_code(req_tdata);
            expected_codes.push_back(item);
         end
         // Track configuration writes; spare indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_AMBIENT_TEMP: ambient_r <= csr_data[7:0];
               REG_CAL_G1:       g1_r      <= csr_data[7:0];
               REG_CAL_G2:       g2_r      <= csr_data;
               REG_CAL_G3:       g3_r      <= csr_data[7:0];
               REG_HEAT_RANGE:   range_r   <= csr_data[1:0];
               REG_HEAT_VALUE:   hv_r      <= csr_data[7:0];
               default: ;
            endcase
         end
         pending_count <= expected_codes.size();
      end
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: stimulus top for the heater resistance code block
// Drives directed and random target temperatures under several calibration
// settings, with random stalls on both streams, and reports the verdict.
// ---------------------------------------------------------------------------

module tb
   import hrc_pkg::*;
();

   localparam logic [2:0] REG_SPARE_6 = 3'd6;
   localparam logic [2:0] REG_SPARE_7 = 3'd7;
   localparam int IDLE_PCT      = 34;
   localparam int RAND_PHASES   = 10;
   localparam int PHASE_ITEMS   = 110;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   int          fail_count;
   int          pending_count;

   bit          idle_on;
   bit          hold_req;

   heater_resistance_code dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   heater_code_checker chk (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block wedges
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Response side: random back pressure, plus one long hold-off on request
   initial begin
      int hold_left;
      bit hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left  = hold_left - 1;
         end else if (idle_on) begin
            rsp_tready = ($urandom_range(99) >= IDLE_PCT);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Offer one target, with random idle cycles ahead of it
   task automatic send_target(input logic [15:0] target);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         req_tdata  = 16'($urandom);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = target;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop offering and wait until every prediction has been answered
   task automatic drain_results();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [15:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic write_config(input logic [15:0] amb, input logic [15:0] g1,
                               input logic [15:0] g2, input logic [15:0] g3,
                               input logic [15:0] range, input logic [15:0] hv);
      csr_write(REG_AMBIENT_TEMP, amb);
      csr_write(REG_CAL_G1, g1);
      csr_write(REG_CAL_G2, g2);
      csr_write(REG_CAL_G3, g3);
      csr_write(REG_HEAT_RANGE, range);
      csr_write(REG_HEAT_VALUE, hv);
      if ($urandom_range(1)) csr_write(REG_SPARE_6, 16'($urandom));
      else                   csr_write(REG_SPARE_7, 16'($urandom));
      csr_valid = 1'b0;
   endtask

   // Register value of the given width: minimum, maximum or random,
   // with random bits above the register width
   function automatic logic [15:0] pick_reg_data(input int width, input bit is_signed);
      int mask, lo, hi, d;
      mask = (1 << width) - 1;
      lo   = is_signed ? (1 << (width - 1)) : 0;
      hi   = is_signed ? (mask >> 1) : mask;
      d    = $urandom;
      case ($urandom_range(3))
         0: d = (d & ~mask) | lo;
         1: d = (d & ~mask) | hi;
         default: ;
      endcase
      return d[15:0];
   endfunction

   function automatic logic [15:0] pick_target();
      int sel;
      sel = $urandom_range(99);
      if (sel < 5)  return 16'd400;
      if (sel < 10) return 16'd401;
      if (sel < 70) return 16'($urandom_range(400));
      return 16'($urandom);
   endfunction

   initial begin
      logic [15:0] directed_targets[$];
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      idle_on    = 1'b1;
      hold_req   = 1'b0;
      reset      = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset configuration: limits of the target, the clamp and bit patterns
      directed_targets = '{16'd0, 16'd1, 16'd25, 16'd200, 16'd399, 16'd400, 16'd401,
                           16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA, 16'd100};
      foreach (directed_targets[i]) send_target(directed_targets[i]);

      // All registers at their maximum
      drain_results();
      write_config(16'h007F, 16'h007F, 16'h7FFF, 16'h007F, 16'h0003, 16'h007F);
      directed_targets = '{16'd0, 16'd1, 16'd400, 16'd401, 16'hFFFF};
      foreach (directed_targets[i]) send_target(directed_targets[i]);

      // All registers at their minimum, upper data bits set
      drain_results();
      write_config(16'hFF80, 16'hFF80, 16'h8000, 16'hFF80, 16'hFFFC, 16'hFF80);
      foreach (directed_targets[i]) send_target(directed_targets[i]);

      // Setting whose rounded result goes negative and wraps
      drain_results();
      write_config(16'h0019, 16'h0080, 16'h0000, 16'h0000, 16'h0003, 16'h007F);
      directed_targets = '{16'd0, 16'd123, 16'd400, 16'hFFFF};
      foreach (directed_targets[i]) send_target(directed_targets[i]);

      // Random phases, each with a fresh configuration
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain_results();
         write_config(pick_reg_data(8, 1'b1), pick_reg_data(8, 1'b1),
                      pick_reg_data(16, 1'b1), pick_reg_data(8, 1'b1),
                      pick_reg_data(2, 1'b0), pick_reg_data(8, 1'b1));
         idle_on = (ph != 1);
         if (ph == 3) hold_req = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Pause the sender midway until every result is back
            if (ph == 5 && n == PHASE_ITEMS / 2) drain_results();
            send_target(pick_target());
         end
      end
      idle_on = 1'b1;

      // Wait out the pipeline, then give the verdict
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
